// ----- rtl/dial_pkg.sv -----
// shared types, constants and helpers of the door intrusion alarm logic
`default_nettype none

package dial_pkg;

  // payload widths
  localparam int MODE_W     = 2;
  localparam int NOW_W      = 32;
  localparam int DWELL_W    = 16;
  localparam int EV_W       = 3;
  localparam int AL_W       = 2;
  localparam int HOUR_W     = 5;
  localparam int LOITER_MSW = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [HOUR_W-1:0]     CurHourRst     = 5'd12;
  localparam logic [HOUR_W-1:0]     NightStartRst  = 5'd22;
  localparam logic [HOUR_W-1:0]     NightEndRst    = 5'd6;
  localparam logic [DWELL_W-1:0]    LoiterRst      = 16'd10;
  localparam logic [LOITER_MSW-1:0] LoiterMsRst    = 26'd10000;

  // milliseconds per second and dwell saturation point
  localparam logic [LOITER_MSW-1:0] MsPerSec       = 26'd1000;
  localparam logic [NOW_W-1:0]      DwellSatMs     = 32'd65536000;
  localparam logic [DWELL_W-1:0]    DwellMax       = 16'hFFFF;

  // divide by 125 after a shift by 3: q = (x * Recip125) >> DivShift, exact for x < 2^23
  localparam int                    DivInW         = 23;
  localparam int                    RecipW         = 24;
  localparam int                    DivShift       = 30;
  localparam logic [RecipW-1:0]     Recip125       = 24'd8589935;

  typedef enum logic [MODE_W-1:0] {
    MODE_UPDATE = 2'd0,
    MODE_ACK    = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE          = 3'd0,
    EV_NIGHT_INTRUDE = 3'd1,
    EV_LOITER        = 3'd2,
    EV_DOORBELL      = 3'd3,
    EV_DOOR_OPEN     = 3'd4
  } event_t;

  typedef enum logic [AL_W-1:0] {
    AL_NONE    = 2'd0,
    AL_WARNING = 2'd1,
    AL_ALARM   = 2'd2
  } alert_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUR_HOUR     = 3'd0,
    REG_NIGHT_START  = 3'd1,
    REG_NIGHT_END    = 3'd2,
    REG_LOITER_SEC   = 3'd3,
    REG_NIGHT_OVR_ON = 3'd4,
    REG_NIGHT_FORCED = 3'd5
  } cfg_idx_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [DWELL_W-1:0]    loiter_s;
    logic [LOITER_MSW-1:0] loiter_ms;
    logic                  night;
  } dial_cfg_t;

  // per-update sensor flags handed to the event picker
  typedef struct packed {
    logic night;
    logic door_rise;
    logic bell_rise;
    logic loiter;
  } dial_flags_t;

  // event picker result
  typedef struct packed {
    event_t event_code;
    alert_t alert_level;
    logic   changed;
  } dial_ev_res_t;

  function automatic alert_t alert_for(input event_t ev, input logic night);
    alert_t al;
    unique case (ev)
      EV_NIGHT_INTRUDE: al = AL_ALARM;
      EV_LOITER:        al = AL_WARNING;
      EV_DOOR_OPEN:     al = night ? AL_ALARM : AL_NONE;
      default:          al = AL_NONE;
    endcase
    return al;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dial_in_if.sv -----
// sensor item channel: valid, ready and the input payload
`default_nettype none

interface dial_in_if import dial_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic               motion;
  logic               bell;
  logic               door_open;
  logic [NOW_W-1:0]   now_ms;

  modport source (output valid, mode, motion, bell, door_open, now_ms, input ready);
  modport sink   (input valid, mode, motion, bell, door_open, now_ms, output ready);
endinterface

`default_nettype wire

// ----- rtl/dial_out_if.sv -----
// result channel: valid, ready and the status snapshot
`default_nettype none

interface dial_out_if import dial_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [AL_W-1:0]    alert_level;
  logic [DWELL_W-1:0] dwell_seconds;
  logic               night_flag;
  logic [EV_W-1:0]    event_code;
  logic               changed;

  modport source (output valid, alert_level, dwell_seconds, night_flag, event_code, changed,
                  input ready);
  modport sink   (input valid, alert_level, dwell_seconds, night_flag, event_code, changed,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/dial_cfg_regs.sv -----
// configuration registers, night window and loiter threshold in milliseconds
`default_nettype none

module dial_cfg_regs import dial_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output dial_cfg_t                  cfg_o
);

  logic [HOUR_W-1:0]     cur_hour_r,    cur_hour_nxt;
  logic [HOUR_W-1:0]     night_start_r, night_start_nxt;
  logic [HOUR_W-1:0]     night_end_r,   night_end_nxt;
  logic [DWELL_W-1:0]    loiter_r,      loiter_nxt;
  logic [LOITER_MSW-1:0] loiter_ms_r,   loiter_ms_nxt;
  logic                  ovr_on_r,      ovr_on_nxt;
  logic                  forced_r,      forced_nxt;

  always_comb begin
    cur_hour_nxt    = cur_hour_r;
    night_start_nxt = night_start_r;
    night_end_nxt   = night_end_r;
    loiter_nxt      = loiter_r;
    loiter_ms_nxt   = loiter_ms_r;
    ovr_on_nxt      = ovr_on_r;
    forced_nxt      = forced_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_CUR_HOUR:     cur_hour_nxt    = cfg_wdata[HOUR_W-1:0];
        REG_NIGHT_START:  night_start_nxt = cfg_wdata[HOUR_W-1:0];
        REG_NIGHT_END:    night_end_nxt   = cfg_wdata[HOUR_W-1:0];
        REG_LOITER_SEC: begin
          loiter_nxt    = cfg_wdata[DWELL_W-1:0];
          // threshold kept in ms so loiter compares against the raw time difference
          loiter_ms_nxt = LOITER_MSW'(cfg_wdata[DWELL_W-1:0]) * MsPerSec;
        end
        REG_NIGHT_OVR_ON: ovr_on_nxt      = cfg_wdata[0];
        REG_NIGHT_FORCED: forced_nxt      = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_hour_r    <= CurHourRst;
      night_start_r <= NightStartRst;
      night_end_r   <= NightEndRst;
      loiter_r      <= LoiterRst;
      loiter_ms_r   <= LoiterMsRst;
      ovr_on_r      <= 1'b0;
      forced_r      <= 1'b0;
    end else begin
      cur_hour_r    <= cur_hour_nxt;
      night_start_r <= night_start_nxt;
      night_end_r   <= night_end_nxt;
      loiter_r      <= loiter_nxt;
      loiter_ms_r   <= loiter_ms_nxt;
      ovr_on_r      <= ovr_on_nxt;
      forced_r      <= forced_nxt;
    end
  end

  always_comb begin
    cfg_o.loiter_s  = loiter_r;
    cfg_o.loiter_ms = loiter_ms_r;
    cfg_o.night     = ovr_on_r ? forced_r
                               : ((cur_hour_r >= night_start_r) || (cur_hour_r < night_end_r));
  end

endmodule

`default_nettype wire

// ----- rtl/dial_dwell_calc.sv -----
// elapsed time since presence start: whole seconds, saturating, and loiter compare
`default_nettype none

module dial_dwell_calc import dial_pkg::*; (
  input  wire logic [NOW_W-1:0]      now_ms,
  input  wire logic [NOW_W-1:0]      start_ms,
  input  wire logic [LOITER_MSW-1:0] loiter_ms,
  output logic                       not_behind,
  output logic                       loiter_hit,
  output logic [DWELL_W-1:0]         dwell_s
);

  localparam int ProdW = DivInW + RecipW;

  logic [NOW_W-1:0]  diff;
  logic              sat;
  logic [DivInW-1:0] x;
  logic [ProdW-1:0]  prod;

  always_comb begin
    diff       = now_ms - start_ms;
    not_behind = now_ms >= start_ms;
    sat        = diff >= DwellSatMs;
    loiter_hit = diff >= NOW_W'(loiter_ms);
    // below saturation diff fits 26 bits; divide by 8 then by 125
    x          = diff[DivInW+2:3];
    prod       = ProdW'(x) * ProdW'(Recip125);
    dwell_s    = sat ? DwellMax : prod[DivShift +: DWELL_W];
  end

endmodule

`default_nettype wire

// ----- rtl/dial_event_pick.sv -----
// event priority, event and alert update, change detection
`default_nettype none

module dial_event_pick import dial_pkg::*; (
  input  wire dial_flags_t flags,
  input  wire event_t      prev_event,
  input  wire event_t      event_cur,
  input  wire alert_t      alert_cur,
  output dial_ev_res_t     res
);

  event_t ev;
  alert_t al;

  always_comb begin
    priority if (flags.night && flags.door_rise) ev = EV_NIGHT_INTRUDE;
    else if (flags.loiter)                       ev = EV_LOITER;
    else if (flags.bell_rise)                    ev = EV_DOORBELL;
    else if (flags.door_rise)                    ev = EV_DOOR_OPEN;
    else                                         ev = EV_NONE;
  end

  always_comb begin
    res.event_code = event_cur;
    res.changed    = 1'b0;
    priority if (ev != EV_NONE && ev != prev_event) begin
      res.event_code = ev;
      res.changed    = 1'b1;
    end else if (ev == EV_NONE && prev_event != EV_NONE) begin
      res.event_code = EV_NONE;
      res.changed    = 1'b1;
    end
    al              = alert_for(res.event_code, flags.night);
    res.alert_level = al;
    if (al != alert_cur) res.changed = 1'b1;
  end

endmodule

`default_nettype wire

// ----- rtl/door_intrusion_alarm_logic.sv -----
// top level: input register, status state and result handshake
// path: an accepted beat is registered into the input register, then into the status state
// throughput: one beat per cycle while the result side keeps up; the state update for a beat is a single pass through
//   the dwell divide-by-1000 multiplier and the event picker
// reset: rst_n is synchronous and active low; registers return to their default hours,
//   loiter 10 s, and all tracking, event, alert and change state clears
`default_nettype none

module door_intrusion_alarm_logic import dial_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  dial_in_if.sink                    in_ch,
  dial_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  dial_cfg_t cfg;

  // input register stage
  logic              s1_valid_r, s1_valid_nxt;
  logic [MODE_W-1:0] s1_mode_r;
  logic              s1_motion_r;
  logic              s1_bell_r;
  logic              s1_door_r;
  logic [NOW_W-1:0]  s1_now_r;

  // status state, which doubles as the result register
  logic [NOW_W-1:0]   start_r,       start_nxt;
  logic               active_r,      active_nxt;
  logic               bell_seen_r,   bell_seen_nxt;
  logic               prev_bell_r,   prev_bell_nxt;
  logic               prev_door_r,   prev_door_nxt;
  event_t             prev_event_r,  prev_event_nxt;
  logic [DWELL_W-1:0] dwell_r,       dwell_nxt;
  alert_t             alert_r,       alert_nxt;
  event_t             event_r,       event_nxt;
  logic               night_r,       night_nxt;
  logic               changed_r,     changed_nxt;
  logic               out_valid_r,   out_valid_nxt;

  // handshake
  logic in_acc;
  logic s2_ready;
  logic fire;

  // presence tracking for a sensor update
  logic               not_behind;
  logic               loiter_hit;
  logic [DWELL_W-1:0] dwell_calc;
  logic [NOW_W-1:0]   upd_start;
  logic               upd_bell_seen;
  logic [DWELL_W-1:0] upd_dwell;
  logic               upd_dwell_hit;
  dial_flags_t        flags;
  dial_ev_res_t       ev_res;

  dial_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  dial_dwell_calc u_dwell (
    .now_ms     (s1_now_r),
    .start_ms   (start_r),
    .loiter_ms  (cfg.loiter_ms),
    .not_behind (not_behind),
    .loiter_hit (loiter_hit),
    .dwell_s    (dwell_calc)
  );

  dial_event_pick u_event (
    .flags      (flags),
    .prev_event (prev_event_r),
    .event_cur  (event_r),
    .alert_cur  (alert_r),
    .res        (ev_res)
  );

  // the result register frees up when empty or being taken; the input stage follows
  assign s2_ready     = !out_valid_r || out_ch.ready;
  assign fire         = s1_valid_r && s2_ready;
  assign in_ch.ready  = !s1_valid_r || s2_ready;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc)    s1_valid_nxt = 1'b1;
    else if (fire) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (fire)              out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  // presence: new start, ongoing dwell, or cleared when motion is gone
  always_comb begin
    upd_start     = start_r;
    upd_bell_seen = 1'b0;
    upd_dwell     = '0;
    upd_dwell_hit = 1'b0;
    if (s1_motion_r) begin
      upd_dwell     = dwell_r;
      upd_dwell_hit = dwell_r >= cfg.loiter_s;
      if (!active_r) begin
        // fresh presence keeps the old dwell until the next update
        upd_start     = s1_now_r;
        upd_bell_seen = s1_bell_r;
      end else begin
        upd_bell_seen = bell_seen_r | s1_bell_r;
        if (not_behind) begin
          upd_dwell     = dwell_calc;
          upd_dwell_hit = loiter_hit;
        end
      end
    end
    flags.night     = cfg.night;
    flags.door_rise = s1_door_r && !prev_door_r;
    flags.bell_rise = s1_bell_r && !prev_bell_r;
    flags.loiter    = s1_motion_r && !upd_bell_seen && upd_dwell_hit;
  end

  always_comb begin
    start_nxt      = start_r;
    active_nxt     = active_r;
    bell_seen_nxt  = bell_seen_r;
    prev_bell_nxt  = prev_bell_r;
    prev_door_nxt  = prev_door_r;
    prev_event_nxt = prev_event_r;
    dwell_nxt      = dwell_r;
    alert_nxt      = alert_r;
    event_nxt      = event_r;
    night_nxt      = night_r;
    changed_nxt    = changed_r;
    if (fire) begin
      unique case (s1_mode_r)
        MODE_UPDATE: begin
          night_nxt      = cfg.night;
          start_nxt      = upd_start;
          active_nxt     = s1_motion_r;
          bell_seen_nxt  = upd_bell_seen;
          dwell_nxt      = upd_dwell;
          event_nxt      = ev_res.event_code;
          prev_event_nxt = ev_res.event_code;
          alert_nxt      = ev_res.alert_level;
          changed_nxt    = changed_r | ev_res.changed;
          prev_bell_nxt  = s1_bell_r;
          prev_door_nxt  = s1_door_r;
        end
        MODE_ACK: changed_nxt = 1'b0;
        MODE_CLEAR: begin
          // edge history and last picked event survive an alert reset
          alert_nxt     = AL_NONE;
          event_nxt     = EV_NONE;
          changed_nxt   = 1'b1;
          active_nxt    = 1'b0;
          bell_seen_nxt = 1'b0;
          dwell_nxt     = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      start_r      <= '0;
      active_r     <= 1'b0;
      bell_seen_r  <= 1'b0;
      prev_bell_r  <= 1'b0;
      prev_door_r  <= 1'b0;
      prev_event_r <= EV_NONE;
      dwell_r      <= '0;
      alert_r      <= AL_NONE;
      event_r      <= EV_NONE;
      night_r      <= 1'b0;
      changed_r    <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      start_r      <= start_nxt;
      active_r     <= active_nxt;
      bell_seen_r  <= bell_seen_nxt;
      prev_bell_r  <= prev_bell_nxt;
      prev_door_r  <= prev_door_nxt;
      prev_event_r <= prev_event_nxt;
      dwell_r      <= dwell_nxt;
      alert_r      <= alert_nxt;
      event_r      <= event_nxt;
      night_r      <= night_nxt;
      changed_r    <= changed_nxt;
    end
  end

  // input payload needs no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r   <= in_ch.mode;
      s1_motion_r <= in_ch.motion;
      s1_bell_r   <= in_ch.bell;
      s1_door_r   <= in_ch.door_open;
      s1_now_r    <= in_ch.now_ms;
    end
  end

  // result beat is the current status snapshot
  assign out_ch.valid         = out_valid_r;
  assign out_ch.alert_level   = alert_r;
  assign out_ch.dwell_seconds = dwell_r;
  assign out_ch.night_flag    = night_r;
  assign out_ch.event_code    = event_r;
  assign out_ch.changed       = changed_r;

`ifndef SYNTHESIS
  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_mode_r == MODE_ACK |=> !changed_r)
    else $error("acknowledge did not clear the change flag");

  a_clear_alert: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_mode_r == MODE_CLEAR |=> alert_r == AL_NONE && event_r == EV_NONE && changed_r)
    else $error("alert reset left alert, event or change flag");

  a_alarm_cause: assert property (@(posedge clk) disable iff (!rst_n)
    alert_r == AL_ALARM |-> event_r == EV_NIGHT_INTRUDE || event_r == EV_DOOR_OPEN)
    else $error("alarm without intrusion or door event");

  a_dwell_needs_presence: assert property (@(posedge clk) disable iff (!rst_n)
    dwell_r != '0 |-> active_r)
    else $error("dwell held without active presence");

  a_bell_needs_presence: assert property (@(posedge clk) disable iff (!rst_n)
    bell_seen_r |-> active_r)
    else $error("doorbell flag held without active presence");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/door_intrusion_alarm_logic_tb.sv -----
// self-checking testbench for the door intrusion alarm logic: directed and random sensor beats
`timescale 1ns / 100ps

module door_intrusion_alarm_logic_tb;
  import dial_pkg::*;

  // mode 3 is not an operation, the block must leave its state alone
  localparam logic [MODE_W-1:0]    MODE_SPARE   = 2'd3;
  // indexes past the register file, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [NOW_W-1:0]     MS_IN_SECOND = 32'd1000;
  localparam logic [DWELL_W-1:0]   DWELL_TOP    = 16'hFFFF;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASES          = 8;
  localparam int BEATS_PER_PHASE = 75;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              motion;
    logic              bell;
    logic              door;
    logic [NOW_W-1:0]  now_ms;
  } sensor_beat_t;

  typedef struct packed {
    logic [AL_W-1:0]    alert;
    logic [DWELL_W-1:0] dwell;
    logic               night;
    logic [EV_W-1:0]    ev_code;
    logic               changed;
  } status_t;

  // tracks the alarm state beat by beat and holds the status snapshots still owed by the block
  class alarm_status_board;
    // register copy
    logic [HOUR_W-1:0]  hour_now, night_from, night_until;
    logic [DWELL_W-1:0] loiter_limit;
    logic               override_on, override_night;
    // tracking state
    logic [NOW_W-1:0]   seen_since;
    logic               someone_here, bell_heard, bell_was, door_was;
    event_t             last_pick, event_now;
    alert_t             alert_now;
    logic [DWELL_W-1:0] dwell_now;
    logic               night_now, dirty;

    status_t pending[$];
    int      mismatches;
    int      checked;
    int      pick_hits[8];
    int      dwell_pinned;

    function new();
      hour_now       = 5'd12;
      night_from     = 5'd22;
      night_until    = 5'd6;
      loiter_limit   = 16'd10;
      override_on    = 1'b0;
      override_night = 1'b0;
      seen_since     = '0;
      someone_here   = 1'b0;
      bell_heard     = 1'b0;
      bell_was       = 1'b0;
      door_was       = 1'b0;
      last_pick      = EV_NONE;
      event_now      = EV_NONE;
      alert_now      = AL_NONE;
      dwell_now      = '0;
      night_now      = 1'b0;
      dirty          = 1'b0;
      mismatches     = 0;
      checked        = 0;
      dwell_pinned   = 0;
      foreach (pick_hits[i]) pick_hits[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CUR_HOUR:     hour_now       = data[HOUR_W-1:0];
        REG_NIGHT_START:  night_from     = data[HOUR_W-1:0];
        REG_NIGHT_END:    night_until    = data[HOUR_W-1:0];
        REG_LOITER_SEC:   loiter_limit   = data[DWELL_W-1:0];
        REG_NIGHT_OVR_ON: override_on    = data[0];
        REG_NIGHT_FORCED: override_night = data[0];
        default: ;
      endcase
    endfunction

    // one accepted sensor beat: advance the tracking state, queue the snapshot it yields
    function void note_beat(sensor_beat_t b);
      status_t            want;
      logic               night, door_rise;
      logic [NOW_W-1:0]   secs;
      event_t             pick;
      alert_t             al;
      if (b.mode == MODE_UPDATE) begin
        night = override_on ? override_night
                            : ((hour_now >= night_from) || (hour_now < night_until));
        night_now = night;
        if (b.motion && !someone_here) begin
          seen_since   = b.now_ms;
          someone_here = 1'b1;
          bell_heard   = 1'b0;
        end else if (b.motion) begin
          // a clock that runs behind the start leaves dwell where it was
          if (b.now_ms >= seen_since) begin
            secs = (b.now_ms - seen_since) / MS_IN_SECOND;
            if (secs >= 32'(DWELL_TOP)) dwell_pinned++;
            dwell_now = (secs > 32'(DWELL_TOP)) ? DWELL_TOP : secs[DWELL_W-1:0];
          end
        end else begin
          someone_here = 1'b0;
        end
        if (b.bell) bell_heard = 1'b1;
        if (!b.motion) begin
          bell_heard = 1'b0;
          dwell_now  = '0;
        end
        door_rise = b.door && !door_was;
        if (night && door_rise)                                      pick = EV_NIGHT_INTRUDE;
        else if (someone_here && !bell_heard && dwell_now >= loiter_limit) pick = EV_LOITER;
        else if (b.bell && !bell_was)                                pick = EV_DOORBELL;
        else if (door_rise)                                          pick = EV_DOOR_OPEN;
        else                                                         pick = EV_NONE;
        pick_hits[pick]++;
        if (pick != EV_NONE && pick != last_pick) begin
          event_now = pick;
          dirty     = 1'b1;
        end else if (pick == EV_NONE && last_pick != EV_NONE) begin
          event_now = EV_NONE;
          dirty     = 1'b1;
        end
        last_pick = event_now;
        case (event_now)
          EV_NIGHT_INTRUDE: al = AL_ALARM;
          EV_LOITER:        al = AL_WARNING;
          EV_DOOR_OPEN:     al = night ? AL_ALARM : AL_NONE;
          default:          al = AL_NONE;
        endcase
        if (al != alert_now) begin
          alert_now = al;
          dirty     = 1'b1;
        end
        bell_was = b.bell;
        door_was = b.door;
      end else if (b.mode == MODE_ACK) begin
        dirty = 1'b0;
      end else if (b.mode == MODE_CLEAR) begin
        // last pick and the previous levels survive an alert clear
        alert_now    = AL_NONE;
        event_now    = EV_NONE;
        dirty        = 1'b1;
        someone_here = 1'b0;
        bell_heard   = 1'b0;
        dwell_now    = '0;
      end
      want.alert   = alert_now;
      want.dwell   = dwell_now;
      want.night   = night_now;
      want.ev_code = event_now;
      want.changed = dirty;
      pending.push_back(want);
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: status beat with none owed: alert=%0d dwell=%0d night=%0d ev=%0d chg=%0d",
                   $time, got.alert, got.dwell, got.night, got.ev_code, got.changed);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.alert !== want.alert || got.dwell !== want.dwell || got.night !== want.night ||
          got.ev_code !== want.ev_code || got.changed !== want.changed) begin
        mismatches++;
        // fields in order: alert, dwell, night, event, changed
        if (mismatches <= 10)
          $display("%0t: status mismatch exp %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                   $time, want.alert, want.dwell, want.night, want.ev_code, want.changed,
                   got.alert, got.dwell, got.night, got.ev_code, got.changed);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dial_in_if  in_ch ();
  dial_out_if out_ch ();

  door_intrusion_alarm_logic DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  alarm_status_board board;

  // idle draw limits per side, changed from phase to phase
  int in_gap_max  = 12;
  int out_gap_max = 12;
  int beats_sent;
  int settings_applied;
  int cycle_count;

  // random visitor model: presence runs, rare bell presses, door toggles, a moving clock
  logic             visitor_here;
  logic             visitor_rings;
  logic             bell_level;
  logic             door_level;
  int               run_left;
  logic [NOW_W-1:0] clock_ms;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // both channels are sampled at the edge, before this edge's updates land
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready === 1'b1)
        board.note_beat('{in_ch.mode, in_ch.motion, in_ch.bell, in_ch.door_open, in_ch.now_ms});
      if (out_ch.valid === 1'b1 && out_ch.ready)
        board.check_status('{out_ch.alert_level, out_ch.dwell_seconds, out_ch.night_flag,
                             out_ch.event_code, out_ch.changed});
    end
  end

  // result side: stall a random number of cycles before taking each beat
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  function automatic sensor_beat_t make_beat(logic [MODE_W-1:0] mode, logic motion, logic bell,
                                             logic door, logic [NOW_W-1:0] now_ms);
    sensor_beat_t b;
    b.mode   = mode;
    b.motion = motion;
    b.bell   = bell;
    b.door   = door;
    b.now_ms = now_ms;
    return b;
  endfunction

  // offer one beat after a random gap; valid stays up afterwards for back-to-back beats
  task automatic send_beat(sensor_beat_t b);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= b.mode;
    in_ch.motion    <= b.motion;
    in_ch.bell      <= b.bell;
    in_ch.door_open <= b.door;
    in_ch.now_ms    <= b.now_ms;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    beats_sent++;
  endtask

  // drop valid and wait until every owed snapshot came back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    board.write_reg(idx, data);
    @(posedge clk);
  endtask

  // full register setting, only once the block is idle; junk puts noise above the field bits
  task automatic apply_setting(logic [HOUR_W-1:0] hour, logic [HOUR_W-1:0] start_h,
                               logic [HOUR_W-1:0] end_h, logic [DWELL_W-1:0] loiter,
                               logic ovr, logic forced, logic junk);
    logic [CFG_DATA_W-HOUR_W-1:0] hi;
    logic [CFG_DATA_W-2:0]        hi1;
    drain_results();
    hi  = junk ? (CFG_DATA_W-HOUR_W)'($urandom) : '0;
    write_reg(REG_CUR_HOUR, {hi, hour});
    hi  = junk ? (CFG_DATA_W-HOUR_W)'($urandom) : '0;
    write_reg(REG_NIGHT_START, {hi, start_h});
    hi  = junk ? (CFG_DATA_W-HOUR_W)'($urandom) : '0;
    write_reg(REG_NIGHT_END, {hi, end_h});
    write_reg(REG_LOITER_SEC, loiter);
    hi1 = junk ? (CFG_DATA_W-1)'($urandom) : '0;
    write_reg(REG_NIGHT_OVR_ON, {hi1, ovr});
    hi1 = junk ? (CFG_DATA_W-1)'($urandom) : '0;
    write_reg(REG_NIGHT_FORCED, {hi1, forced});
    if (junk) begin
      // writes past the register file must not land anywhere
      write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
      write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  initial begin
    int roll;
    board            = new();
    beats_sent       = 0;
    settings_applied = 0;
    cycle_count      = 0;
    visitor_here     = 1'b0;
    visitor_rings    = 1'b0;
    bell_level       = 1'b0;
    door_level       = 1'b0;
    run_left         = 0;
    clock_ms         = '0;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_UPDATE;
    in_ch.motion    <= 1'b0;
    in_ch.bell      <= 1'b0;
    in_ch.door_open <= 1'b0;
    in_ch.now_ms    <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_CUR_HOUR;
    cfg_wdata       <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part, reset register values: daytime, loiter after 10 s ----
    send_beat(make_beat(MODE_UPDATE, 1'b0, 1'b0, 1'b0, 32'd0));
    // a visitor shows up and rings: dwell counts, the bell press wins, loiter is masked
    send_beat(make_beat(MODE_UPDATE, 1'b1, 1'b0, 1'b0, 32'd1000));
    send_beat(make_beat(MODE_UPDATE, 1'b1, 1'b0, 1'b0, 32'd5500));
    send_beat(make_beat(MODE_UPDATE, 1'b1, 1'b1, 1'b0, 32'd6000));
    send_beat(make_beat(MODE_UPDATE, 1'b1, 1'b1, 1'b0, 32'd7000));
    send_beat(make_beat(MODE_UPDATE, 1'b1, 1'b0, 1'b0, 32'd20000));
    send_beat(make_beat(MODE_ACK, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));
    // presence ends, then a silent visitor loiters
    send_beat(make_beat(MODE_UPDATE, 1'b0, 1'b0, 1'b0, 32'd21000));
    send_beat(make_beat(MODE_UPDATE, 1'b1, 1'b0, 1'b0, 32'd100000));
    send_beat(make_beat(MODE_UPDATE, 1'b1, 1'b0, 1'b0, 32'd111000));
    // clock behind the presence start: dwell holds
    send_beat(make_beat(MODE_UPDATE, 1'b1, 1'b0, 1'b0, 32'd50000));
    // loiter outranks an opening door
    send_beat(make_beat(MODE_UPDATE, 1'b1, 1'b0, 1'b1, 32'd120000));
    // dwell saturates just past the top and at the far end of the clock
    send_beat(make_beat(MODE_UPDATE, 1'b1, 1'b0, 1'b1, 32'd100000 + 32'd65541000));
    send_beat(make_beat(MODE_UPDATE, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF));
    send_beat(make_beat(MODE_CLEAR, 1'b0, 1'b0, 1'b0, 32'd0));
    send_beat(make_beat(MODE_SPARE, 1'b1, 1'b1, 1'b1, $urandom));
    // daytime door opening: event without alarm
    send_beat(make_beat(MODE_UPDATE, 1'b0, 1'b0, 1'b0, 32'd200000));
    send_beat(make_beat(MODE_UPDATE, 1'b0, 1'b0, 1'b1, 32'd201000));
    send_beat(make_beat(MODE_ACK, 1'b0, 1'b0, 1'b0, 32'd0));

    // late evening: an opening door is an intrusion, a bell press stays a plain event
    apply_setting(5'd23, 5'd22, 5'd6, 16'd10, 1'b0, 1'b0, 1'b0);
    send_beat(make_beat(MODE_UPDATE, 1'b0, 1'b0, 1'b0, 32'd300000));
    send_beat(make_beat(MODE_UPDATE, 1'b0, 1'b0, 1'b1, 32'd301000));
    send_beat(make_beat(MODE_UPDATE, 1'b1, 1'b1, 1'b1, 32'd302000));

    // manual day wins over the hour window
    apply_setting(5'd23, 5'd22, 5'd6, 16'd10, 1'b1, 1'b0, 1'b0);
    send_beat(make_beat(MODE_UPDATE, 1'b0, 1'b0, 1'b0, 32'd303000));
    send_beat(make_beat(MODE_UPDATE, 1'b0, 1'b0, 1'b1, 32'd304000));

    // ---- random part: one register setting per phase ----
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_setting(5'd12, 5'd22, 5'd6, 16'd10, 1'b0, 1'b0, 1'b0);   // plain day
        1: apply_setting(5'd3, 5'd22, 5'd6, 16'd0, 1'b0, 1'b0, 1'b0);     // small hours, loiter at once
        2: apply_setting(5'd31, 5'd24, 5'd0, DWELL_TOP, 1'b0, 1'b0, 1'b1); // hours past 23
        3: apply_setting(5'd10, 5'd22, 5'd6, 16'd2, 1'b1, 1'b1, 1'b0);    // forced night
        4: apply_setting(5'd0, 5'd0, 5'd23, 16'd5, 1'b1, 1'b0, 1'b1);     // forced day
        default:
          apply_setting(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                        5'($urandom_range(0, 31)), 16'($urandom_range(0, 30)),
                        1'($urandom), 1'($urandom), 1'b1);
      endcase
      in_gap_max  = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 4 : 12);
      out_gap_max = (ph % 4 == 0) ? 0 : ((ph % 4 == 1) ? 12 : 3);
      if (ph >= 5) clock_ms = $urandom;
      if (ph == 7) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 60000);   // wraps mid phase

      for (int i = 0; i < BEATS_PER_PHASE; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          send_beat(make_beat(MODE_ACK, 1'($urandom), 1'($urandom), 1'($urandom), $urandom));
        end else if (roll < 14) begin
          send_beat(make_beat(MODE_CLEAR, 1'($urandom), 1'($urandom), 1'($urandom), $urandom));
        end else if (roll < 17) begin
          send_beat(make_beat(MODE_SPARE, 1'($urandom), 1'($urandom), 1'($urandom), $urandom));
        end else if (roll < 25) begin
          // noise: levels and timestamp with no relation to the visit
          send_beat(make_beat(MODE_UPDATE, 1'($urandom), 1'($urandom), 1'($urandom), $urandom));
        end else begin
          if (run_left == 0) begin
            visitor_here  = !visitor_here;
            visitor_rings = ($urandom_range(0, 2) == 0);
            run_left      = visitor_here ? $urandom_range(1, 25) : $urandom_range(1, 4);
          end
          run_left--;
          roll = $urandom_range(0, 99);
          if (roll < 80)      clock_ms += $urandom_range(0, 2500);
          else if (roll < 93) clock_ms += $urandom_range(2500, 30000);
          else if (roll < 95) clock_ms += $urandom_range(60000000, 70000000);   // toward saturation
          else                clock_ms -= $urandom_range(1, 5000);              // clock steps back
          bell_level = visitor_rings && ($urandom_range(0, 3) == 0);
          if ($urandom_range(0, 4) == 0) door_level = !door_level;
          send_beat(make_beat(MODE_UPDATE, visitor_here, bell_level, door_level, clock_ms));
        end
      end
    end

    drain_results();
    repeat (4) @(posedge clk);

    $display("covered %0d beats over %0d register settings, %0d status beats checked",
             beats_sent, settings_applied, board.checked);
    $display("picks: night %0d, loiter %0d, bell %0d, door %0d; dwell at top %0d times",
             board.pick_hits[EV_NIGHT_INTRUDE], board.pick_hits[EV_LOITER],
             board.pick_hits[EV_DOORBELL], board.pick_hits[EV_DOOR_OPEN], board.dwell_pinned);
    if (board.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
